// ----- hw/rtl/ipq_pkg.sv -----
// Shared types and constants of the instruction prefetch queue.
`default_nettype none

package ipq_pkg;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_REP   = 2'd3
  } mode_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SegW    = 16;
  localparam int unsigned OffW    = 16;
  localparam int unsigned AddrW   = 20;
  localparam int unsigned WaitW   = 8;
  localparam int unsigned WsW     = 4;
  localparam int unsigned OutCntW = 5;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // capture the accepted word
    logic tick;      // advance the wait counter
    logic push1;     // store the first fetched byte
    logic push2;     // store the second fetched byte
    logic pop;       // read the head byte
    logic flush;     // load new address and empty the queue
    logic rep;       // push the opcode back at the head
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    mode_e mode;
    logic  tick_fetch;
    logic  second_ok;
    logic  can_pop;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ipq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ipq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ipq_ctrl.sv -----
// Controller state machine that sequences one word through the queue datapath.
`default_nettype none

module ipq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ipq_pkg::sts_t sts_i,
  output ipq_pkg::cmd_t      cmd_o
);

  import ipq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SECOND,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  // Decode commands and next state
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (sts_i.mode)
          MODE_TICK: begin
            cmd.tick  = 1'b1;
            cmd.push1 = sts_i.tick_fetch;
            if (sts_i.tick_fetch) begin
              state_d = ST_SECOND;
            end
          end
          MODE_READ:  cmd.pop   = sts_i.can_pop;
          MODE_FLUSH: cmd.flush = 1'b1;
          MODE_REP:   cmd.rep   = 1'b1;
          default:    cmd       = '0;
        endcase
      end
      ST_SECOND: begin
        cmd.push2 = sts_i.second_ok;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        cmd.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

// ----- hw/rtl/ipq_dp.sv -----
// Queue datapath: word capture, indices, counters, fetch address, byte store, result register.
`default_nettype none

module ipq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ipq_pkg::cmd_t                  cmd_i,
  output ipq_pkg::sts_t                       sts_o,
  input  wire ipq_pkg::mode_e                 mode_i,
  input  wire logic [ipq_pkg::WsW-1:0]        wait_states_i,
  input  wire logic                           word_bus_i,
  input  wire logic [ipq_pkg::ByteW-1:0]      mem_first_byte_i,
  input  wire logic [ipq_pkg::ByteW-1:0]      mem_second_byte_i,
  input  wire logic [ipq_pkg::SegW-1:0]       new_segment_i,
  input  wire logic [ipq_pkg::OffW-1:0]       new_offset_i,
  input  wire logic [ipq_pkg::ByteW-1:0]      rep_opcode_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic      [ipq_pkg::AddrW-1:0]      fetch_address_o,
  output logic                                read_valid_o,
  output logic      [ipq_pkg::ByteW-1:0]      read_byte_o,
  output logic      [ipq_pkg::OutCntW-1:0]    queue_count_o
);

  import ipq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Captured word
  mode_e            mode_q;
  logic [WsW-1:0]   ws_q;
  logic             wb_q;
  logic [ByteW-1:0] b0_q, b1_q, op_q;
  logic [SegW-1:0]  seg_in_q;
  logic [OffW-1:0]  off_in_q;

  // Queue state
  logic [IdxW-1:0]  head_q, tail_q;
  logic [CntW-1:0]  count_q;
  logic [WaitW-1:0] wait_q;
  logic [SegW-1:0]  fseg_q;
  logic [OffW-1:0]  foff_q;
  logic             pop_q;

  // Result register
  logic               out_valid_q;
  logic [AddrW-1:0]   out_addr_q;
  logic               out_rv_q;
  logic [ByteW-1:0]   out_byte_q;
  logic [OutCntW-1:0] out_cnt_q;

  logic [IdxW-1:0]      head_next, head_prev, tail_next, tail_prev;
  logic [WaitW-1:0]     wait_inc;
  logic                 full;
  logic [AddrW-1:0]     cur_addr;
  logic [CntW+OutCntW-1:0] cnt_ext;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [ByteW-1:0]     ram_wdata;
  logic [ByteW-1:0]     ram_rdata;

  // Wrap indices at the queue depth
  assign head_next = (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign head_prev = (head_q == '0) ? IdxW'(QUEUE_DEPTH - 1) : head_q - IdxW'(1);
  assign tail_next = (tail_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + IdxW'(1);
  assign tail_prev = (tail_q == '0) ? IdxW'(QUEUE_DEPTH - 1) : tail_q - IdxW'(1);

  // Saturate the wait counter
  assign wait_inc = (wait_q == '1) ? wait_q : wait_q + WaitW'(1);
  assign full     = (count_q >= CntW'(QUEUE_DEPTH));
  assign cur_addr = {fseg_q, 4'b0000} + {4'b0000, foff_q};
  assign cnt_ext  = {{OutCntW{1'b0}}, count_q};

  assign sts_o.mode       = mode_q;
  assign sts_o.tick_fetch = !full && (wait_inc >= {{(WaitW-WsW){1'b0}}, ws_q});
  assign sts_o.second_ok  = !full && wb_q && foff_q[0];
  assign sts_o.can_pop    = (count_q >= CntW'(2));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Byte store write port: fetched bytes at the tail, pushed-back opcode before the head
  assign ram_we    = cmd_i.push1 || cmd_i.push2 || cmd_i.rep;
  assign ram_waddr = cmd_i.rep ? head_prev : tail_q;
  assign ram_wdata = cmd_i.rep ? op_q : (cmd_i.push2 ? b1_q : b0_q);

  ipq_ram #(
    .Width(ByteW),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.pop),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q   <= mode_i;
      ws_q     <= wait_states_i;
      wb_q     <= word_bus_i;
      b0_q     <= mem_first_byte_i;
      b1_q     <= mem_second_byte_i;
      seg_in_q <= new_segment_i;
      off_in_q <= new_offset_i;
      op_q     <= rep_opcode_i;
    end
  end

  // Update queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      wait_q  <= '0;
      fseg_q  <= '0;
      foff_q  <= '0;
      pop_q   <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        pop_q <= 1'b0;
      end
      if (cmd_i.tick) begin
        wait_q <= cmd_i.push1 ? '0 : wait_inc;
      end
      if (cmd_i.push1 || cmd_i.push2) begin
        tail_q  <= tail_next;
        foff_q  <= foff_q + OffW'(1);
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.pop) begin
        head_q  <= head_next;
        count_q <= count_q - CntW'(1);
        pop_q   <= 1'b1;
      end else if (cmd_i.flush) begin
        fseg_q  <= seg_in_q;
        foff_q  <= off_in_q;
        count_q <= '0;
        head_q  <= '0;
        tail_q  <= '0;
        wait_q  <= '0;
      end else if (cmd_i.rep) begin
        head_q <= head_prev;
        // Drop the newest byte when full so it is fetched again
        if (full) begin
          tail_q <= tail_prev;
          foff_q <= foff_q - OffW'(1);
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_addr_q <= cur_addr;
      out_rv_q   <= pop_q;
      out_byte_q <= pop_q ? ram_rdata : '0;
      out_cnt_q  <= cnt_ext[OutCntW-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fetch_address_o = out_addr_q;
  assign read_valid_o    = out_rv_q;
  assign read_byte_o     = out_byte_q;
  assign queue_count_o   = out_cnt_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cpu_instruction_prefetch_queue_core.sv -----
// Instruction prefetch queue top level: stream ports, controller and datapath.
// Each word passes the execute state, the second-fetch state for a tick that fetches, and the done
// state, which loads the result register once it is free; only then is a new word accepted. The byte
// store has a single write port (two fetched bytes are written in turn) and a registered read.
// Reset clears indices, counters and the fetch address; stored bytes are left as they are.
`default_nettype none

module cpu_instruction_prefetch_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] wait_states, [4] word_bus, [12:5] mem_first_byte, [20:13] mem_second_byte,
  // [36:21] new_segment, [52:37] new_offset, [60:53] rep_opcode, [63:61] zero
  input  wire logic [63:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [19:0] fetch_address, [27:20] read_byte, [32:28] queue_count, [39:33] zero
  output logic [39:0]      m_axis_tdata,
  // [0] read_valid
  output logic             m_axis_tuser
);

  import ipq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [AddrW-1:0]   fetch_address;
  logic [ByteW-1:0]   read_byte;
  logic [OutCntW-1:0] queue_count;

  ipq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ipq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_e'(s_axis_tuser)),
    .wait_states_i    (s_axis_tdata[3:0]),
    .word_bus_i       (s_axis_tdata[4]),
    .mem_first_byte_i (s_axis_tdata[12:5]),
    .mem_second_byte_i(s_axis_tdata[20:13]),
    .new_segment_i    (s_axis_tdata[36:21]),
    .new_offset_i     (s_axis_tdata[52:37]),
    .rep_opcode_i     (s_axis_tdata[60:53]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .fetch_address_o  (fetch_address),
    .read_valid_o     (m_axis_tuser),
    .read_byte_o      (read_byte),
    .queue_count_o    (queue_count)
  );

  // Pack the result word
  assign m_axis_tdata = {7'b0000000, queue_count, read_byte, fetch_address};

  // One word in flight: no new word straight after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted while another is in flight");

  // A second fetched byte only follows a first one
  a_push2_after_push1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push2 |-> $past(cmd.push1))
    else $error("second fetch without a first fetch");

  // A result appears only after the controller loads it
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

endmodule

`default_nettype wire
